// File: hdl/ftsa_pkg.sv
// Shared types and constants for the frequency track slot allocator.
// No dependencies; imported by every module of the block.
package ftsa_pkg;

    localparam int TRACK_COUNT = 4;
    localparam int TRACK_IDX_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

    localparam int SLOT_W   = 3;
    localparam int CENTRE_W = 28;
    localparam int SEQ_W    = 32;
    localparam int WINDOW_W = 27;
    localparam int EXPIRY_W = 31;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 27'd5000000;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 31'd16;

    // Register indexes (paddr[2])
    localparam logic REG_MATCH_WINDOW = 1'b0;
    localparam logic REG_EXPIRY       = 1'b1;

    typedef logic [SLOT_W-1:0]          slot_t;
    typedef logic signed [CENTRE_W-1:0] centre_t;
    typedef logic [SEQ_W-1:0]           seq_t;
    typedef logic [CENTRE_W-1:0]        dist_t;
    typedef logic [TRACK_IDX_W-1:0]     track_idx_t;
    typedef logic [TRACK_COUNT-1:0]     track_mask_t;

    // Decision handed from the selector to the track table
    typedef struct packed {
        track_idx_t  sel;
        track_mask_t expired;
        logic        restart;
    } ftsa_upd_t;

endpackage

// File: hdl/ftsa_cfg.sv
// APB-style configuration registers: match window and expiry limit.
// Depends on ftsa_pkg.
module ftsa_cfg import ftsa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [WINDOW_W-1:0]   match_window,
    output logic [EXPIRY_W-1:0]   expiry_tiles
);

    logic [WINDOW_W-1:0] window_reg;
    logic [EXPIRY_W-1:0] expiry_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            expiry_reg <= EXPIRY_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MATCH_WINDOW: window_reg <= pwdata[WINDOW_W-1:0];
                REG_EXPIRY:       expiry_reg <= pwdata[EXPIRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MATCH_WINDOW: prdata = {{(PDATA_W-WINDOW_W){1'b0}}, window_reg};
            REG_EXPIRY:       prdata = {{(PDATA_W-EXPIRY_W){1'b0}}, expiry_reg};
            default:          prdata = '0;
        endcase
    end

    assign match_window = window_reg;
    assign expiry_tiles = expiry_reg;

endmodule

// File: hdl/ftsa_select.sv
// Combinational track choice: expiry, nearest match, free track, oldest track.
// Depends on ftsa_pkg.
module ftsa_select import ftsa_pkg::*; (
    input  track_mask_t         track_active,
    input  slot_t               track_slot   [TRACK_COUNT],
    input  centre_t             track_centre [TRACK_COUNT],
    input  seq_t                track_seen   [TRACK_COUNT],
    input  slot_t               slot,
    input  centre_t             centre,
    input  seq_t                seq,
    input  logic [WINDOW_W-1:0] match_window,
    input  logic [EXPIRY_W-1:0] expiry_tiles,
    output ftsa_upd_t           upd
);

    seq_t                    age     [TRACK_COUNT];
    dist_t                   dist_hz [TRACK_COUNT];
    logic [TRACK_COUNT-1:0]  age_ok;
    logic [TRACK_COUNT-1:0]  live;
    logic [TRACK_COUNT-1:0]  near;
    track_mask_t             expired;

    // Per-track age, distance and status, all in parallel
    always_comb begin
        logic signed [CENTRE_W:0] diff;
        for (int i = 0; i < TRACK_COUNT; i++) begin
            age[i]     = seq - track_seen[i];
            age_ok[i]  = !age[i][SEQ_W-1];
            expired[i] = track_active[i] && age_ok[i] &&
                         (age[i] > {1'b0, expiry_tiles});
            live[i]    = track_active[i] && !expired[i];
            diff       = {track_centre[i][CENTRE_W-1], track_centre[i]} -
                         {centre[CENTRE_W-1], centre};
            dist_hz[i] = diff[CENTRE_W] ? CENTRE_W'(-diff) : diff[CENTRE_W-1:0];
            near[i]    = live[i] && (track_slot[i] == slot) &&
                         (dist_hz[i] <= {1'b0, match_window});
        end
    end

    always_comb begin
        logic       found;
        dist_t      best_dist;
        seq_t       oldest;
        track_idx_t sel;
        found     = 1'b0;
        best_dist = '0;
        oldest    = '0;
        sel       = '0;
        // nearest match, lower index wins on a tie
        for (int i = 0; i < TRACK_COUNT; i++) begin
            if (near[i] && (!found || dist_hz[i] < best_dist)) begin
                found     = 1'b1;
                best_dist = dist_hz[i];
                sel       = TRACK_IDX_W'(i);
            end
        end
        // first free track
        for (int i = 0; i < TRACK_COUNT; i++) begin
            if (!found && !live[i]) begin
                found = 1'b1;
                sel   = TRACK_IDX_W'(i);
            end
        end
        // oldest valid age, later index wins on a tie
        if (!found) begin
            for (int i = 0; i < TRACK_COUNT; i++) begin
                if (age_ok[i] && age[i] >= oldest) begin
                    oldest = age[i];
                    sel    = TRACK_IDX_W'(i);
                end
            end
        end
        upd.sel     = sel;
        upd.expired = expired;
        upd.restart = !near[sel];
    end

endmodule

// File: hdl/ftsa_track_table.sv
// Track state registers, expiry clearing and overwrite of the chosen track.
// Depends on ftsa_pkg.
module ftsa_track_table import ftsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        upd_en,
    input  ftsa_upd_t   upd,
    input  slot_t       slot,
    input  centre_t     centre,
    input  seq_t        seq,
    output track_mask_t track_active,
    output slot_t       track_slot   [TRACK_COUNT],
    output centre_t     track_centre [TRACK_COUNT],
    output seq_t        track_seen   [TRACK_COUNT]
);

    track_mask_t active_reg;
    track_mask_t active_next;
    slot_t       slot_reg   [TRACK_COUNT];
    centre_t     centre_reg [TRACK_COUNT];
    seq_t        seen_reg   [TRACK_COUNT];

    always_comb begin
        active_next = active_reg;
        if (upd_en) begin
            active_next          = active_reg & ~upd.expired;
            active_next[upd.sel] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            for (int i = 0; i < TRACK_COUNT; i++) begin
                slot_reg[i]   <= '0;
                centre_reg[i] <= '0;
                seen_reg[i]   <= '0;
            end
        end else begin
            active_reg <= active_next;
            if (upd_en) begin
                slot_reg[upd.sel]   <= slot;
                centre_reg[upd.sel] <= centre;
                seen_reg[upd.sel]   <= seq;
            end
        end
    end

    assign track_active = active_reg;
    assign track_slot   = slot_reg;
    assign track_centre = centre_reg;
    assign track_seen   = seen_reg;

    // only active tracks can expire
    a_expire_active: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |-> (upd.expired & ~active_reg) == '0)
        else $error("expired mask names an inactive track");

    // joining without restart needs a live track
    a_join_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_en && !upd.restart) |-> (active_reg[upd.sel] && !upd.expired[upd.sel]))
        else $error("join without restart on a dead track");

    a_chosen_active: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |=> active_reg[$past(upd.sel)])
        else $error("chosen track not active after update");

endmodule

// File: hdl/frequency_track_slot_allocator_unit.sv
// Registered path: input register, then result register; a held result keeps the item in the input register.
// One item per cycle while m_tready does not hold the result; the track table updates on the edge that loads it.
// Stalls only when the result register is held by m_tready low.
// Reset (aresetn, synchronous, active low): all tracks inactive and zero,
// match window 5000000 Hz, expiry limit 16 tiles, both item registers empty.
module frequency_track_slot_allocator_unit import ftsa_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] capture_slot, [30:3] centre_offset_hz, [62:31] sequence_number, [63] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] chosen_track, [2] state_restart, [6:3] expired_mask, [7] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic                in_valid_reg;
    slot_t               slot_reg;
    centre_t             centre_reg;
    seq_t                seq_reg;
    logic                out_valid_reg;
    logic [1:0]          chosen_reg;
    logic                restart_reg;
    logic [3:0]          expired_reg;
    logic                advance;
    logic [WINDOW_W-1:0] match_window;
    logic [EXPIRY_W-1:0] expiry_tiles;
    track_mask_t         track_active;
    slot_t               track_slot   [TRACK_COUNT];
    centre_t             track_centre [TRACK_COUNT];
    seq_t                track_seen   [TRACK_COUNT];
    ftsa_upd_t           upd;
    logic [31:0]         sel_wide;
    logic [31:0]         expired_wide;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ftsa_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .match_window (match_window),
        .expiry_tiles (expiry_tiles)
    );

    ftsa_select u_select (
        .track_active (track_active),
        .track_slot   (track_slot),
        .track_centre (track_centre),
        .track_seen   (track_seen),
        .slot         (slot_reg),
        .centre       (centre_reg),
        .seq          (seq_reg),
        .match_window (match_window),
        .expiry_tiles (expiry_tiles),
        .upd          (upd)
    );

    ftsa_track_table u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd_en       (advance),
        .upd          (upd),
        .slot         (slot_reg),
        .centre       (centre_reg),
        .seq          (seq_reg),
        .track_active (track_active),
        .track_slot   (track_slot),
        .track_centre (track_centre),
        .track_seen   (track_seen)
    );

    assign sel_wide     = 32'(upd.sel);
    assign expired_wide = 32'(upd.expired);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            slot_reg   <= s_tdata[2:0];
            centre_reg <= s_tdata[30:3];
            seq_reg    <= s_tdata[62:31];
        end
        if (advance) begin
            chosen_reg  <= sel_wide[1:0];
            restart_reg <= upd.restart;
            expired_reg <= expired_wide[3:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, expired_reg, restart_reg, chosen_reg};

    a_out_from_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a held item");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed item lost");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// File: sim/frequency_track_slot_allocator_unit_tb.sv
// Testbench for the frequency track slot allocator: an in-bench track table predicts each
// allocation, which is checked against the result stream. Depends on ftsa_pkg and the block.
`timescale 1ns / 1ps

module frequency_track_slot_allocator_unit_tb;
    import ftsa_pkg::*;

    typedef struct packed {
        slot_t   slot;
        centre_t centre;
        seq_t    seq;
    } proposal_t;

    typedef struct {
        track_idx_t  track;
        logic        restart;
        track_mask_t expired;
    } alloc_t;

    localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
    localparam logic [EXPIRY_W-1:0] EXPIRY_MAX = '1;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [2:0] capture_slot, [30:3] centre_offset_hz, [62:31] sequence_number, [63] zero
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [1:0] chosen_track, [2] state_restart, [6:3] expired_mask, [7] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    frequency_track_slot_allocator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Predictor state: register copies and the track table
    logic [WINDOW_W-1:0] cfg_window = WINDOW_RESET;
    logic [EXPIRY_W-1:0] cfg_expiry = EXPIRY_RESET;
    logic                trk_active [TRACK_COUNT];
    slot_t               trk_slot   [TRACK_COUNT];
    centre_t             trk_centre [TRACK_COUNT];
    seq_t                trk_seen   [TRACK_COUNT];

    proposal_t proposal_q [$];
    alloc_t    alloc_expect_q [$];
    int        mismatch_count = 0;
    bit        gaps_on = 1'b1;
    int        rx_hold_req = 0;

    // Stimulus generator state
    seq_t    seq_cursor = '0;
    slot_t   recent_slot   [TRACK_COUNT];
    centre_t recent_centre [TRACK_COUNT];

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    function automatic logic [CENTRE_W:0] centre_gap(centre_t a, centre_t b);
        logic signed [CENTRE_W:0] diff;
        diff = {a[CENTRE_W-1], a} - {b[CENTRE_W-1], b};
        return diff[CENTRE_W] ? -diff : diff;
    endfunction

    // Expire, match nearest, else first free, else oldest; then overwrite the track
    function automatic alloc_t allocate_track(proposal_t p);
        alloc_t              r;
        int                  sel;
        logic [CENTRE_W:0]   best;
        logic [CENTRE_W:0]   d;
        seq_t                age;
        seq_t                oldest;
        sel       = -1;
        best      = '1;
        r.expired = '0;
        for (int i = 0; i < TRACK_COUNT; i++) begin
            age = p.seq - trk_seen[i];
            if (trk_active[i] && !age[SEQ_W-1] && age > {1'b0, cfg_expiry}) begin
                trk_active[i] = 1'b0;
                r.expired[i]  = 1'b1;
            end
            if (trk_active[i] && trk_slot[i] == p.slot) begin
                d = centre_gap(trk_centre[i], p.centre);
                if (d <= cfg_window && d < best) begin
                    sel  = i;
                    best = d;
                end
            end
        end
        for (int i = 0; i < TRACK_COUNT; i++)
            if (sel < 0 && !trk_active[i])
                sel = i;
        if (sel < 0) begin
            // age of 2^31 or above means the sequence went backwards: never the oldest
            sel    = 0;
            oldest = '0;
            for (int i = 0; i < TRACK_COUNT; i++) begin
                age = p.seq - trk_seen[i];
                if (!age[SEQ_W-1] && age >= oldest) begin
                    sel    = i;
                    oldest = age;
                end
            end
        end
        r.restart = !trk_active[sel] || trk_slot[sel] != p.slot ||
                    centre_gap(trk_centre[sel], p.centre) > cfg_window;
        r.track   = track_idx_t'(sel);
        trk_active[sel] = 1'b1;
        trk_slot[sel]   = p.slot;
        trk_centre[sel] = p.centre;
        trk_seen[sel]   = p.seq;
        return r;
    endfunction

    // Mostly proposals near recent ones on recent slots, with slowly rising sequence numbers
    function automatic proposal_t gen_proposal();
        proposal_t     p;
        int            j;
        int            k;
        longint        span;
        longint        c;
        j = $urandom_range(0, TRACK_COUNT - 1);
        k = $urandom_range(0, 99);
        p.slot = (k < 70) ? recent_slot[j] : slot_t'($urandom_range(0, 7));
        k = $urandom_range(0, 99);
        if (k < 65) begin
            span = longint'(cfg_window) + longint'(cfg_window) / 4 + 2;
            c = longint'(recent_centre[j]) + longint'($urandom_range(0, int'(span)));
            if ($urandom_range(0, 1))
                c = longint'(recent_centre[j]) - (c - longint'(recent_centre[j]));
            p.centre = centre_t'(c);
        end else if (k < 72) begin
            case ($urandom_range(0, 3))
                0:       p.centre = {1'b0, {(CENTRE_W-1){1'b1}}};
                1:       p.centre = {1'b1, {(CENTRE_W-1){1'b0}}};
                2:       p.centre = '0;
                default: p.centre = '1;
            endcase
        end else begin
            p.centre = centre_t'($urandom());
        end
        k = $urandom_range(0, 99);
        if (k < 82)
            seq_cursor += $urandom_range(0, 3);
        else if (k < 90)
            seq_cursor += seq_t'(cfg_expiry) + $urandom_range(0, 3);  // around the expiry edge
        else if (k < 95)
            seq_cursor -= $urandom_range(1, 20);
        else if (k < 98)
            seq_cursor = $urandom();
        else
            seq_cursor += 32'h7FFF_FFFF + $urandom_range(0, 2);       // around the 2^31 age edge
        p.seq = seq_cursor;
        recent_slot[j]   = p.slot;
        recent_centre[j] = p.centre;
        return p;
    endfunction

    task automatic push_proposal(slot_t slot, centre_t centre, seq_t seq);
        proposal_t p;
        p.slot   = slot;
        p.centre = centre;
        p.seq    = seq;
        proposal_q.push_back(p);
    endtask

    task automatic apb_write(logic idx, logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MATCH_WINDOW)
            cfg_window = value[WINDOW_W-1:0];
        else
            cfg_expiry = value[EXPIRY_W-1:0];
    endtask

    task automatic apb_read(logic idx);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_MATCH_WINDOW) begin
            if (prdata != PDATA_W'(cfg_window))
                report_mismatch("match window readback", prdata, cfg_window);
        end else begin
            if (prdata != PDATA_W'(cfg_expiry))
                report_mismatch("expiry readback", prdata, cfg_expiry);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (proposal_q.size() != 0 || s_tvalid || alloc_expect_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Input driver
    proposal_t in_flight;
    int        send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
            for (int i = 0; i < TRACK_COUNT; i++) begin
                trk_active[i] = 1'b0;
                trk_slot[i]   = '0;
                trk_centre[i] = '0;
                trk_seen[i]   = '0;
            end
        end else begin
            if (s_tvalid && s_tready)
                alloc_expect_q.push_back(allocate_track(in_flight));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (proposal_q.size() > 0) begin
                    in_flight = proposal_q.pop_front();
                    s_tdata  <= {1'b0, in_flight.seq, in_flight.centre, in_flight.slot};
                    s_tvalid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    int stall_left = 0;
    int hold_left  = 0;

    always @(posedge aclk) begin : result_monitor
        alloc_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (alloc_expect_q.size() == 0) begin
                    report_mismatch("result with no item pending", m_tdata, 0);
                end else begin
                    want = alloc_expect_q.pop_front();
                    if (m_tdata[TRACK_IDX_W-1:0] != want.track)
                        report_mismatch("chosen_track", m_tdata[TRACK_IDX_W-1:0], want.track);
                    if (m_tdata[2] != want.restart)
                        report_mismatch("state_restart", m_tdata[2], want.restart);
                    if (m_tdata[6:3] != want.expired)
                        report_mismatch("expired_mask", m_tdata[6:3], want.expired);
                end
            end
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [WINDOW_W-1:0] win;
        logic [EXPIRY_W-1:0] exp_lim;
        for (int i = 0; i < TRACK_COUNT; i++) begin
            recent_slot[i]   = slot_t'(i);
            recent_centre[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_read(REG_MATCH_WINDOW);
        apb_read(REG_EXPIRY);

        // Directed: field extremes, exact window edge, ties, backwards and wrapping sequences
        push_proposal(0, 0, 0);
        push_proposal(7, {1'b0, {(CENTRE_W-1){1'b1}}}, 1);
        push_proposal(7, {1'b1, {(CENTRE_W-1){1'b0}}}, 2);
        push_proposal(0, 5000000, 3);
        push_proposal(0, 10000001, 4);
        push_proposal(5, 0, 5);                     // table full: oldest goes
        push_proposal(1, 0, 32'h100);               // everything expires
        push_proposal(2, -3000000, 32'h101);
        push_proposal(2, 3000000, 32'h101);
        push_proposal(2, 0, 32'h102);               // equidistant: lower index
        push_proposal(3, 0, 32'h102);
        push_proposal(4, 0, 32'h0F0);               // gone backwards: no valid age
        push_proposal(6, 0, 32'h103);
        push_proposal(1, 0, 32'h200);
        push_proposal(2, 0, 32'h200);
        push_proposal(3, 0, 32'h200);
        push_proposal(4, 0, 32'h200);
        push_proposal(5, 0, 32'h200);               // equal ages: higher index
        push_proposal(0, 0, 32'hFFFF_FFFE);
        push_proposal(0, 100, 32'h0000_0003);       // across the wrap
        push_proposal(0, {1'b0, {(CENTRE_W-1){1'b1}}}, 4);
        push_proposal(0, {1'b1, {(CENTRE_W-1){1'b0}}}, 4);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    win     = '0;
                    exp_lim = '0;
                end
                1: begin
                    win     = WINDOW_MAX;
                    exp_lim = EXPIRY_MAX;
                end
                default: begin
                    win     = WINDOW_W'($urandom_range(1000, 8000000));
                    exp_lim = EXPIRY_W'($urandom_range(2, 40));
                end
            endcase
            // upper bits beyond each register are junk and must be dropped
            apb_write(REG_MATCH_WINDOW, {5'($urandom()), win});
            apb_write(REG_EXPIRY, {1'($urandom()), exp_lim});
            apb_read(REG_MATCH_WINDOW);
            apb_read(REG_EXPIRY);
            gaps_on = (ph != 4);
            if (ph == 1)
                rx_hold_req = 300;
            for (int n = 0; n < 140; n++) begin
                if (ph == 2 && n == 70)
                    wait_drained();
                proposal_q.push_back(gen_proposal());
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
